@@ hw/rtl/lpft_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the LRU pinned frame table.
// Used by lpft_store, lpft_scan and lru_pinned_frame_table; no dependencies.
package lpft_pkg;

    localparam int FRAMES  = 16;
    localparam int IDX_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int PAGE_W  = 32;
    localparam int PIN_W   = 8;
    localparam int STAMP_W = 32;

    localparam logic [PIN_W-1:0] PIN_MAX = 8'hFF;

    localparam logic [1:0] CMD_FETCH = 2'd0;
    localparam logic [1:0] CMD_UNPIN = 2'd1;
    localparam logic [1:0] CMD_FLUSH = 2'd2;

    localparam logic [2:0] ST_HIT        = 3'd0;
    localparam logic [2:0] ST_MISS       = 3'd1;
    localparam logic [2:0] ST_FULL       = 3'd2;
    localparam logic [2:0] ST_UNPIN      = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd4;
    localparam logic [2:0] ST_FLUSH_WB   = 3'd5;
    localparam logic [2:0] ST_FLUSH_DONE = 3'd6;

    typedef logic [IDX_W-1:0] t_idx;

    typedef struct packed {
        logic [1:0]        command;
        logic [PAGE_W-1:0] page_number;
        logic              mark_dirty;
    } t_lpft_in;

    typedef struct packed {
        logic [2:0]        status;
        logic [3:0]        frame_index;
        logic              writeback_valid;
        logic [PAGE_W-1:0] writeback_page;
        logic              last;
    } t_lpft_out;

    typedef struct packed {
        logic               valid;
        logic [PAGE_W-1:0]  page;
        logic               dirty;
        logic [PIN_W-1:0]   pins;
        logic [STAMP_W-1:0] stamp;
    } t_lpft_frame;

    typedef struct packed {
        logic               set_valid;
        logic               we_page;
        logic               we_dirty;
        logic               we_pins;
        logic               we_stamp;
        t_idx               idx;
        logic [PAGE_W-1:0]  page;
        logic               dirty;
        logic [PIN_W-1:0]   pins;
        logic [STAMP_W-1:0] stamp;
    } t_lpft_wr;

    typedef struct packed {
        logic              hit;
        t_idx              hit_idx;
        logic [PIN_W-1:0]  hit_pins;
        logic              empty;
        t_idx              empty_idx;
        logic              vic;
        t_idx              vic_idx;
        logic [PAGE_W-1:0] vic_page;
        logic              vic_dirty;
    } t_lpft_scan;

endpackage

@@ hw/rtl/lpft_store.sv @@
`timescale 1ns / 1ps
// Frame metadata registers: valid, page, dirty, pin count and stamp per frame.
// One read index, one write port with per-field enables. Depends on lpft_pkg.
module lpft_store (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  lpft_pkg::t_idx       i_rd_idx,
    output lpft_pkg::t_lpft_frame o_frame,
    input  lpft_pkg::t_lpft_wr   i_wr
);
    import lpft_pkg::*;

    logic [FRAMES-1:0]  r_valid;
    logic [PAGE_W-1:0]  r_page  [FRAMES];
    logic               r_dirty [FRAMES];
    logic [PIN_W-1:0]   r_pins  [FRAMES];
    logic [STAMP_W-1:0] r_stamp [FRAMES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_wr.idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we_page) begin
            r_page[i_wr.idx] <= i_wr.page;
        end
        if (i_wr.we_dirty) begin
            r_dirty[i_wr.idx] <= i_wr.dirty;
        end
        if (i_wr.we_pins) begin
            r_pins[i_wr.idx] <= i_wr.pins;
        end
        if (i_wr.we_stamp) begin
            r_stamp[i_wr.idx] <= i_wr.stamp;
        end
    end

    always_comb begin
        o_frame.valid = r_valid[i_rd_idx];
        o_frame.page  = r_page[i_rd_idx];
        o_frame.dirty = r_dirty[i_rd_idx];
        o_frame.pins  = r_pins[i_rd_idx];
        o_frame.stamp = r_stamp[i_rd_idx];
    end

endmodule

@@ hw/rtl/lpft_scan.sv @@
`timescale 1ns / 1ps
// Shared compare unit: looks at one frame per step and keeps the first match,
// the first empty frame and the least recent unpinned frame. Depends on lpft_pkg.
module lpft_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_step,
    input  lpft_pkg::t_idx        i_idx,
    input  lpft_pkg::t_lpft_frame i_frame,
    input  logic [31:0]           i_key,
    output lpft_pkg::t_lpft_scan  o_res
);
    import lpft_pkg::*;

    logic               r_hit;
    t_idx               r_hit_idx;
    logic [PIN_W-1:0]   r_hit_pins;
    logic               r_empty;
    t_idx               r_empty_idx;
    logic               r_vic;
    t_idx               r_vic_idx;
    logic [STAMP_W-1:0] r_vic_stamp;
    logic [PAGE_W-1:0]  r_vic_page;
    logic               r_vic_dirty;

    logic is_hit;
    logic is_empty;
    logic is_vic;

    always_comb begin
        is_hit   = !r_hit && i_frame.valid && (i_frame.page == i_key);
        is_empty = !r_empty && !i_frame.valid;
        is_vic   = i_frame.valid && (i_frame.pins == '0) &&
                   (!r_vic || (i_frame.stamp < r_vic_stamp));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
            r_vic   <= 1'b0;
        end else if (i_start) begin
            r_hit   <= 1'b0;
            r_empty <= 1'b0;
            r_vic   <= 1'b0;
        end else if (i_step) begin
            if (is_hit) begin
                r_hit      <= 1'b1;
                r_hit_idx  <= i_idx;
                r_hit_pins <= i_frame.pins;
            end
            if (is_empty) begin
                r_empty     <= 1'b1;
                r_empty_idx <= i_idx;
            end
            if (is_vic) begin
                r_vic       <= 1'b1;
                r_vic_idx   <= i_idx;
                r_vic_stamp <= i_frame.stamp;
                r_vic_page  <= i_frame.page;
                r_vic_dirty <= i_frame.dirty;
            end
        end
    end

    always_comb begin
        o_res.hit       = r_hit;
        o_res.hit_idx   = r_hit_idx;
        o_res.hit_pins  = r_hit_pins;
        o_res.empty     = r_empty;
        o_res.empty_idx = r_empty_idx;
        o_res.vic       = r_vic;
        o_res.vic_idx   = r_vic_idx;
        o_res.vic_page  = r_vic_page;
        o_res.vic_dirty = r_vic_dirty;
    end

    // a found match stays found until the next scan starts
    a_hit_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hit && !i_start) |=> r_hit)
        else $error("match lost during scan");

    // the victim stamp never grows within a scan
    a_vic_monotone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vic && !i_start) |=> (r_vic && r_vic_stamp <= $past(r_vic_stamp)))
        else $error("victim stamp increased");

    // an unpinned victim is always valid
    a_vic_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !i_start && is_vic) |-> i_frame.valid)
        else $error("victim taken from empty frame");

endmodule

@@ hw/rtl/lru_pinned_frame_table.sv @@
`timescale 1ns / 1ps
// Page cache frame table with LRU replacement and pin counts (top level).
// Depends on lpft_pkg, lpft_store and lpft_scan.
//
// Fetch and unpin step through every frame, one frame per cycle, in the shared
// compare unit, then S_COMMIT writes the update and the result; a stalled output
// holds S_COMMIT. The next input transfer can follow once the commit is done.
// Flush walks all frames and gives a write-back result for each valid dirty
// frame, then a final result; a stalled output holds both. The input
// stalls while an item is at work; the result sits in an output register so
// the next item can be taken while it waits. Command 3 is taken and dropped.
module lru_pinned_frame_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  lpft_pkg::t_lpft_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output lpft_pkg::t_lpft_out o_out_data
);
    import lpft_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_FLUSH,
        S_DONE
    } t_state;

    localparam t_idx LAST_IDX = t_idx'(FRAMES - 1);

    t_state             r_state, n_state;
    t_idx               r_ptr, n_ptr;
    logic [STAMP_W-1:0] r_clock, n_clock;
    logic [1:0]         r_cmd, n_cmd;
    logic [PAGE_W-1:0]  r_page, n_page;
    logic               r_mark, n_mark;
    logic               r_out_valid, n_out_valid;
    t_lpft_out          r_out, n_out;

    t_lpft_frame frame;
    t_lpft_wr    wr;
    t_lpft_scan  sr;
    logic        scan_start;
    logic        scan_step;
    logic        out_free;
    logic        in_xfer;
    t_idx        miss_idx;
    logic        miss_wb;

    lpft_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (r_ptr),
        .o_frame  (frame),
        .i_wr     (wr)
    );

    lpft_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (scan_start),
        .i_step  (scan_step),
        .i_idx   (r_ptr),
        .i_frame (frame),
        .i_key   (r_page),
        .o_res   (sr)
    );

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign miss_idx    = sr.empty ? sr.empty_idx : sr.vic_idx;
    assign miss_wb     = !sr.empty && sr.vic_dirty;

    always_comb begin
        n_state     = r_state;
        n_ptr       = r_ptr;
        n_clock     = r_clock;
        n_cmd       = r_cmd;
        n_page      = r_page;
        n_mark      = r_mark;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        wr          = '0;
        scan_start  = 1'b0;
        scan_step   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_cmd  = i_in_data.command;
                    n_page = i_in_data.page_number;
                    n_mark = i_in_data.mark_dirty;
                    n_ptr  = '0;
                    case (i_in_data.command)
                        CMD_FETCH: begin
                            n_clock    = r_clock + 1'b1;
                            scan_start = 1'b1;
                            n_state    = S_SCAN;
                        end
                        CMD_UNPIN: begin
                            scan_start = 1'b1;
                            n_state    = S_SCAN;
                        end
                        CMD_FLUSH: begin
                            n_state = S_FLUSH;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                scan_step = 1'b1;
                if (r_ptr == LAST_IDX) begin
                    n_state = S_COMMIT;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.last  = 1'b1;
                    n_state     = S_IDLE;
                    if (r_cmd == CMD_FETCH) begin
                        if (sr.hit) begin
                            wr.idx      = sr.hit_idx;
                            wr.we_pins  = 1'b1;
                            wr.pins     = (sr.hit_pins == PIN_MAX) ? PIN_MAX
                                                                   : sr.hit_pins + 1'b1;
                            wr.we_stamp = 1'b1;
                            wr.stamp    = r_clock;
                            n_out.status      = ST_HIT;
                            n_out.frame_index = 4'(sr.hit_idx);
                        end else if (sr.empty || sr.vic) begin
                            wr.idx       = miss_idx;
                            wr.set_valid = 1'b1;
                            wr.we_page   = 1'b1;
                            wr.page      = r_page;
                            wr.we_pins   = 1'b1;
                            wr.pins      = PIN_W'(1);
                            wr.we_dirty  = 1'b1;
                            wr.dirty     = 1'b0;
                            wr.we_stamp  = 1'b1;
                            wr.stamp     = r_clock;
                            n_out.status          = ST_MISS;
                            n_out.frame_index     = 4'(miss_idx);
                            n_out.writeback_valid = miss_wb;
                            n_out.writeback_page  = miss_wb ? sr.vic_page : '0;
                        end else begin
                            n_out.status = ST_FULL;
                        end
                    end else begin
                        if (sr.hit) begin
                            wr.idx      = sr.hit_idx;
                            wr.we_pins  = 1'b1;
                            wr.pins     = (sr.hit_pins == '0) ? '0 : sr.hit_pins - 1'b1;
                            wr.we_dirty = r_mark;
                            wr.dirty    = 1'b1;
                            n_out.status      = ST_UNPIN;
                            n_out.frame_index = 4'(sr.hit_idx);
                        end else begin
                            n_out.status = ST_NOT_FOUND;
                        end
                    end
                end
            end
            S_FLUSH: begin
                if (!(frame.valid && frame.dirty) || out_free) begin
                    if (frame.valid && frame.dirty) begin
                        wr.idx      = r_ptr;
                        wr.we_dirty = 1'b1;
                        wr.dirty    = 1'b0;
                        n_out_valid = 1'b1;
                        n_out       = '0;
                        n_out.status          = ST_FLUSH_WB;
                        n_out.frame_index     = 4'(r_ptr);
                        n_out.writeback_valid = 1'b1;
                        n_out.writeback_page  = frame.page;
                    end
                    if (r_ptr == LAST_IDX) begin
                        n_state = S_DONE;
                    end else begin
                        n_ptr = r_ptr + 1'b1;
                    end
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out        = '0;
                    n_out.status = ST_FLUSH_DONE;
                    n_out.last   = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ptr       <= '0;
            r_clock     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_ptr       <= n_ptr;
            r_clock     <= n_clock;
            r_cmd       <= n_cmd;
            r_page      <= n_page;
            r_mark      <= n_mark;
            r_out_valid <= n_out_valid;
            r_out       <= n_out;
        end
    end

    // advance the use clock on every fetch transfer, and only then
    a_clock_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> (r_clock == $past(r_clock) +
                     ((($past(i_in_data.command) == CMD_FETCH)) ? 32'd1 : 32'd0)))
        else $error("use clock out of step with fetch");

    // flush write-back results never close an item and always carry a page
    a_flush_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == ST_FLUSH_WB) |->
            (!o_out_data.last && o_out_data.writeback_valid))
        else $error("bad flush write-back result");

    // no write-back means a zero page field
    a_wb_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.writeback_valid) |-> (o_out_data.writeback_page == '0))
        else $error("write-back page set without write-back");

endmodule
